### hdl/obd_m01_pkg.sv
// Shared types and constants for the Mode 01 request/response filter.
// No dependencies; used by the frame checker, the core, the top level and the testbench.
package obd_m01_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REQ_ID    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RSP_LOW   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RSP_HIGH  = 2'd3;

  // Configuration reset values
  localparam logic [9:0]  TIMEOUT_RST  = 10'd80;
  localparam logic [10:0] REQ_ID_RST   = 11'h7DF;
  localparam logic [10:0] RSP_LOW_RST  = 11'h7E8;
  localparam logic [10:0] RSP_HIGH_RST = 11'h7EF;

  // Protocol bytes
  localparam logic [7:0] REQ_BYTE0  = 8'h02;
  localparam logic [7:0] REQ_BYTE1  = 8'h01;
  localparam logic [7:0] REPLY_MODE = 8'h41;
  localparam logic [3:0] SF_TYPE    = 4'h0;
  localparam logic [2:0] MAX_BYTES  = 3'd4;
  localparam logic [3:0] MAX_DLC    = 4'd8;
  localparam logic [3:0] REPLY_HDR  = 4'd3;
  localparam logic [3:0] SF_HDR     = 4'd2;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_FRAME = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    EV_REQUEST  = 3'd0,
    EV_IGNORED  = 3'd1,
    EV_ACCEPTED = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_NOTHING  = 3'd4
  } event_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  pid;
    logic [2:0]  required_bytes;
    logic [10:0] frame_id;
    logic        frame_extended;
    logic        frame_remote;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
  } item_t;

  typedef struct packed {
    event_e      event_res;
    logic [10:0] tx_id;
    logic [63:0] tx_payload;
    logic [10:0] ecu_id;
    logic [31:0] reply_data;
  } result_t;

  typedef struct packed {
    logic [9:0]  timeout_ticks;
    logic [10:0] request_id;
    logic [10:0] response_id_low;
    logic [10:0] response_id_high;
  } cfg_t;

  // Wait context the frame checker needs from the core
  typedef struct packed {
    logic [7:0]  pending_pid;
    logic [2:0]  pending_bytes;
    logic        ecu_latched;
    logic [10:0] latched_ecu_id;
  } wait_ctx_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] reply_data;
  } chk_t;

endpackage

### hdl/obd_m01_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing; field names follow the filter's item and result layout.
interface obd_m01_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  pid;
  logic [2:0]  required_bytes;
  logic [10:0] frame_id;
  logic        frame_extended;
  logic        frame_remote;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;

  modport source (output valid, func, pid, required_bytes, frame_id, frame_extended,
                  frame_remote, frame_length, frame_data, input ready);
  modport sink (input valid, func, pid, required_bytes, frame_id, frame_extended,
                frame_remote, frame_length, frame_data, output ready);
endinterface

interface obd_m01_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [10:0] tx_id;
  logic [63:0] tx_payload;
  logic [10:0] ecu_id;
  logic [31:0] reply_data;

  modport source (output valid, event_res, tx_id, tx_payload, ecu_id, reply_data,
                  input ready);
  modport sink (input valid, event_res, tx_id, tx_payload, ecu_id, reply_data,
                output ready);
endinterface

### hdl/obd_m01_chk.sv
// Received-frame checker: frame kind, ID window, ECU match, lengths, mode and PID.
// Also extracts the reply data bytes. Depends on obd_m01_pkg.
module obd_m01_chk (
  input  obd_m01_pkg::item_t     item_i,
  input  obd_m01_pkg::cfg_t      cfg_i,
  input  obd_m01_pkg::wait_ctx_t ctx_i,
  output obd_m01_pkg::chk_t      chk_o
);

  logic [7:0] b0, b1, b2;
  logic [3:0] dlc;
  logic [3:0] need_len;
  logic [3:0] need_sf;
  logic       std_data;
  logic       in_window;
  logic       ecu_match;

  assign b0 = item_i.frame_data[63:56];
  assign b1 = item_i.frame_data[55:48];
  assign b2 = item_i.frame_data[47:40];

  assign dlc      = (item_i.frame_length > obd_m01_pkg::MAX_DLC) ? obd_m01_pkg::MAX_DLC
                                                                 : item_i.frame_length;
  assign need_len = obd_m01_pkg::REPLY_HDR + {1'b0, ctx_i.pending_bytes};
  assign need_sf  = obd_m01_pkg::SF_HDR + {1'b0, ctx_i.pending_bytes};

  assign std_data  = !item_i.frame_extended && !item_i.frame_remote;
  assign in_window = (item_i.frame_id >= cfg_i.response_id_low) &&
                     (item_i.frame_id <= cfg_i.response_id_high);
  assign ecu_match = !ctx_i.ecu_latched || (item_i.frame_id == ctx_i.latched_ecu_id);

  always_comb begin
    chk_o.ok = std_data && in_window && ecu_match &&
               (dlc >= need_len) &&
               (b0[7:4] == obd_m01_pkg::SF_TYPE) &&
               (b0[3:0] >= need_sf) &&
               (b1 == obd_m01_pkg::REPLY_MODE) &&
               (b2 == ctx_i.pending_pid);
    // keep only the bytes the request asked for, first byte on top
    unique case (ctx_i.pending_bytes)
      3'd1:    chk_o.reply_data = {item_i.frame_data[39:32], 24'd0};
      3'd2:    chk_o.reply_data = {item_i.frame_data[39:24], 16'd0};
      3'd3:    chk_o.reply_data = {item_i.frame_data[39:16], 8'd0};
      3'd4:    chk_o.reply_data = item_i.frame_data[39:8];
      default: chk_o.reply_data = '0;
    endcase
  end

endmodule

### hdl/obd_m01_core.sv
// Wait-state machine and result register of the Mode 01 filter.
// Depends on obd_m01_pkg and instantiates obd_m01_chk.
module obd_m01_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  obd_m01_pkg::cfg_t     cfg_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  obd_m01_pkg::item_t    item_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output obd_m01_pkg::result_t  res_o
);

  logic                   waiting_q, waiting_d;
  logic [9:0]             elapsed_q, elapsed_d;
  obd_m01_pkg::wait_ctx_t ctx_q, ctx_d;
  obd_m01_pkg::result_t   res_q, res_d;
  logic                   res_valid_q;
  obd_m01_pkg::chk_t      chk;
  logic                   accept;
  logic [9:0]             elapsed_inc;

  obd_m01_chk u_chk (
    .item_i (item_i),
    .cfg_i  (cfg_i),
    .ctx_i  (ctx_q),
    .chk_o  (chk)
  );

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign accept       = item_valid_i && item_ready_o;
  assign elapsed_inc  = elapsed_q + 10'd1;

  always_comb begin
    waiting_d = waiting_q;
    elapsed_d = elapsed_q;
    ctx_d     = ctx_q;
    res_d     = '0;
    res_d.event_res = obd_m01_pkg::EV_NOTHING;
    unique case (item_i.func)
      obd_m01_pkg::FUNC_START: begin
        ctx_d.pending_pid   = item_i.pid;
        ctx_d.pending_bytes = (item_i.required_bytes > obd_m01_pkg::MAX_BYTES)
                              ? obd_m01_pkg::MAX_BYTES : item_i.required_bytes;
        elapsed_d        = '0;
        waiting_d        = 1'b1;
        res_d.event_res  = obd_m01_pkg::EV_REQUEST;
        res_d.tx_id      = cfg_i.request_id;
        res_d.tx_payload = {obd_m01_pkg::REQ_BYTE0, obd_m01_pkg::REQ_BYTE1, item_i.pid, 40'd0};
      end
      obd_m01_pkg::FUNC_FRAME: begin
        if (waiting_q && chk.ok) begin
          // first good reply picks the ECU for good
          if (!ctx_q.ecu_latched) begin
            ctx_d.ecu_latched    = 1'b1;
            ctx_d.latched_ecu_id = item_i.frame_id;
          end
          waiting_d        = 1'b0;
          res_d.event_res  = obd_m01_pkg::EV_ACCEPTED;
          res_d.ecu_id     = item_i.frame_id;
          res_d.reply_data = chk.reply_data;
        end else begin
          res_d.event_res = obd_m01_pkg::EV_IGNORED;
        end
      end
      obd_m01_pkg::FUNC_TICK: begin
        if (waiting_q) begin
          if (elapsed_inc >= cfg_i.timeout_ticks) begin
            waiting_d       = 1'b0;
            elapsed_d       = '0;
            res_d.event_res = obd_m01_pkg::EV_TIMEOUT;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      elapsed_q   <= '0;
      ctx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        waiting_q <= waiting_d;
        elapsed_q <= elapsed_d;
        ctx_q     <= ctx_d;
      end
      if (item_ready_o) begin
        res_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/obd_mode01_response_filter.sv
// Top level of the Mode 01 request/response filter: configuration registers,
// input register and the core. Depends on obd_m01_pkg, obd_m01_if.sv and obd_m01_core.
//
//   channel  | direction | word
//   ---------+-----------+--------------------------------------------------
//   in_i     | sink      | func, pid, required_bytes, frame fields
//   out_o    | source    | event_res, tx_id, tx_payload, ecu_id, reply_data
//   cfg_*    | write     | cfg_idx_i selects register, cfg_wdata_i value
//
// One word in and one word out per cycle while out_o is ready; each result passes the
// input register, then the result register behind the checks.
// Reset clears the wait state, the latched ECU and both valid flags, and loads the
// register defaults. A stalled result holds while an empty input register takes a word.
module obd_mode01_response_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  obd_m01_in_if.sink                           in_i,
  obd_m01_out_if.source                        out_o,
  input  logic                                 cfg_we_i,
  input  logic [obd_m01_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [obd_m01_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  obd_m01_pkg::cfg_t    cfg_q;
  obd_m01_pkg::item_t   item_q, item_d;
  obd_m01_pkg::result_t res;
  logic                 item_valid_q;
  logic                 core_ready;
  logic                 res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks    <= obd_m01_pkg::TIMEOUT_RST;
      cfg_q.request_id       <= obd_m01_pkg::REQ_ID_RST;
      cfg_q.response_id_low  <= obd_m01_pkg::RSP_LOW_RST;
      cfg_q.response_id_high <= obd_m01_pkg::RSP_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        obd_m01_pkg::CFG_TIMEOUT:  cfg_q.timeout_ticks    <= cfg_wdata_i[9:0];
        obd_m01_pkg::CFG_REQ_ID:   cfg_q.request_id       <= cfg_wdata_i;
        obd_m01_pkg::CFG_RSP_LOW:  cfg_q.response_id_low  <= cfg_wdata_i;
        obd_m01_pkg::CFG_RSP_HIGH: cfg_q.response_id_high <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign item_d.func           = in_i.func;
  assign item_d.pid            = in_i.pid;
  assign item_d.required_bytes = in_i.required_bytes;
  assign item_d.frame_id       = in_i.frame_id;
  assign item_d.frame_extended = in_i.frame_extended;
  assign item_d.frame_remote   = in_i.frame_remote;
  assign item_d.frame_length   = in_i.frame_length;
  assign item_d.frame_data     = in_i.frame_data;

  // input register advances whenever it is empty or the core takes its word
  assign in_i.ready = !item_valid_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= item_d;
    end
  end

  obd_m01_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid_q),
    .item_ready_o (core_ready),
    .item_i       (item_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_o.ready),
    .res_o        (res)
  );

  assign out_o.valid      = res_valid;
  assign out_o.event_res  = res.event_res;
  assign out_o.tx_id      = res.tx_id;
  assign out_o.tx_payload = res.tx_payload;
  assign out_o.ecu_id     = res.ecu_id;
  assign out_o.reply_data = res.reply_data;

endmodule

### tb/obd_mode01_response_filter_tb.sv
// Testbench for obd_mode01_response_filter: random and directed request, frame and tick words,
// checked against a cycle-free model of the Mode 01 exchange kept in a small tracker class.
// Depends on obd_m01_pkg and the channel interfaces in obd_m01_if.sv.
module obd_mode01_response_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_BAD     = 2'd3;
  localparam logic [7:0] MODE01_REPLY = 8'h41;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 145;

  class obd_reply_tracker;
    obd_m01_pkg::cfg_t    regs;
    bit                   waiting;
    logic [7:0]           pend_pid;
    logic [2:0]           pend_bytes;
    logic [9:0]           elapsed;
    bit                   latched;
    logic [10:0]          latched_id;
    obd_m01_pkg::result_t due_results[$];
    int unsigned          fails;
    int unsigned          active_words;
    int unsigned          all_words;
    int unsigned          ev_seen[5];

    function void power_on();
      regs.timeout_ticks    = 10'd80;
      regs.request_id       = 11'h7DF;
      regs.response_id_low  = 11'h7E8;
      regs.response_id_high = 11'h7EF;
      waiting    = 1'b0;
      pend_pid   = '0;
      pend_bytes = '0;
      elapsed    = '0;
      latched    = 1'b0;
      latched_id = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [10:0] val);
      case (idx)
        obd_m01_pkg::CFG_TIMEOUT:  regs.timeout_ticks    = val[9:0];
        obd_m01_pkg::CFG_REQ_ID:   regs.request_id       = val;
        obd_m01_pkg::CFG_RSP_LOW:  regs.response_id_low  = val;
        obd_m01_pkg::CFG_RSP_HIGH: regs.response_id_high = val;
        default: ;
      endcase
    endfunction

    function bit reply_matches(obd_m01_pkg::item_t w);
      logic [3:0] len;
      logic [7:0] b0;
      len = (w.frame_length > 4'd8) ? 4'd8 : w.frame_length;
      b0  = w.frame_data[63:56];
      if (w.frame_extended || w.frame_remote) return 1'b0;
      if (w.frame_id < regs.response_id_low || w.frame_id > regs.response_id_high) return 1'b0;
      if (latched && w.frame_id != latched_id) return 1'b0;
      if (len < 3 + pend_bytes) return 1'b0;
      if (b0[7:4] != 4'h0) return 1'b0;
      if (b0[3:0] < 2 + pend_bytes) return 1'b0;
      if (w.frame_data[55:48] != MODE01_REPLY || w.frame_data[47:40] != pend_pid) return 1'b0;
      return 1'b1;
    endfunction

    // Advance the exchange by one accepted word and queue the result it must produce.
    function void word_accepted(obd_m01_pkg::item_t w);
      obd_m01_pkg::result_t r;
      logic [31:0]          keep;
      r = '0;
      r.event_res = obd_m01_pkg::EV_NOTHING;
      all_words++;
      if (w.func == obd_m01_pkg::FUNC_START ||
          (waiting && (w.func == obd_m01_pkg::FUNC_FRAME || w.func == obd_m01_pkg::FUNC_TICK)))
        active_words++;
      case (w.func)
        obd_m01_pkg::FUNC_START: begin
          pend_pid     = w.pid;
          pend_bytes   = (w.required_bytes > 3'd4) ? 3'd4 : w.required_bytes;
          elapsed      = '0;
          waiting      = 1'b1;
          r.event_res  = obd_m01_pkg::EV_REQUEST;
          r.tx_id      = regs.request_id;
          r.tx_payload = {8'h02, 8'h01, w.pid, 40'h0};
        end
        obd_m01_pkg::FUNC_FRAME: begin
          if (waiting && reply_matches(w)) begin
            keep = (pend_bytes == 3'd0) ? 32'h0 : (32'hFFFF_FFFF << (8 * (4 - pend_bytes)));
            if (!latched) begin
              latched    = 1'b1;
              latched_id = w.frame_id;
            end
            waiting      = 1'b0;
            r.event_res  = obd_m01_pkg::EV_ACCEPTED;
            r.ecu_id     = w.frame_id;
            r.reply_data = w.frame_data[39:8] & keep;
          end else begin
            r.event_res = obd_m01_pkg::EV_IGNORED;
          end
        end
        obd_m01_pkg::FUNC_TICK: begin
          if (waiting) begin
            elapsed = elapsed + 10'd1;
            if (elapsed >= regs.timeout_ticks) begin
              waiting     = 1'b0;
              elapsed     = '0;
              r.event_res = obd_m01_pkg::EV_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
      due_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    function void result_seen(obd_m01_pkg::result_t got);
      obd_m01_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result word: event_res %0d", got.event_res);
        fails++;
        return;
      end
      want = due_results.pop_front();
      ev_seen[want.event_res]++;
      cmp_field("event_res", 64'(want.event_res), 64'(got.event_res));
      cmp_field("tx_id", 64'(want.tx_id), 64'(got.tx_id));
      cmp_field("tx_payload", want.tx_payload, got.tx_payload);
      cmp_field("ecu_id", 64'(want.ecu_id), 64'(got.ecu_id));
      cmp_field("reply_data", 64'(want.reply_data), 64'(got.reply_data));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [10:0] cfg_wdata;
  int unsigned cycle_cnt;
  int          burst_left;
  bit          long_hold_req;

  obd_reply_tracker tracker = new;

  obd_m01_in_if  in_if ();
  obd_m01_out_if out_if ();

  obd_mode01_response_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int new_burst();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
  endfunction

  function automatic obd_m01_pkg::item_t kind_word(input logic [1:0] func);
    obd_m01_pkg::item_t w;
    w.func           = func;
    w.pid            = 8'($urandom);
    w.required_bytes = 3'($urandom);
    w.frame_id       = 11'($urandom);
    w.frame_extended = 1'($urandom);
    w.frame_remote   = 1'($urandom);
    w.frame_length   = 4'($urandom);
    w.frame_data     = {$urandom, $urandom};
    return w;
  endfunction

  function automatic obd_m01_pkg::item_t start_word(input logic [7:0] pid,
                                                    input logic [2:0] nbytes);
    obd_m01_pkg::item_t w;
    w = kind_word(obd_m01_pkg::FUNC_START);
    w.pid            = pid;
    w.required_bytes = nbytes;
    return w;
  endfunction

  // Well-formed reply for whatever request is open right now.
  function automatic obd_m01_pkg::item_t good_reply(input logic [10:0] id);
    obd_m01_pkg::item_t w;
    int                 pb;
    pb = int'(tracker.pend_bytes);
    w = kind_word(obd_m01_pkg::FUNC_FRAME);
    w.frame_id           = id;
    w.frame_extended     = 1'b0;
    w.frame_remote       = 1'b0;
    w.frame_length       = 4'($urandom_range(3 + pb, 15));
    w.frame_data[63:60]  = 4'h0;
    w.frame_data[59:56]  = 4'($urandom_range(2 + pb, 15));
    w.frame_data[55:48]  = MODE01_REPLY;
    w.frame_data[47:40]  = tracker.pend_pid;
    return w;
  endfunction

  function automatic logic [10:0] reply_id();
    logic [10:0] lo, hi;
    lo = tracker.regs.response_id_low;
    hi = tracker.regs.response_id_high;
    if (tracker.latched && $urandom_range(0, 99) < 85) return tracker.latched_id;
    if (lo <= hi) return 11'($urandom_range(lo, hi));
    return 11'($urandom);
  endfunction

  // Corrupt one part of an otherwise good reply.
  function automatic obd_m01_pkg::item_t broken_reply();
    obd_m01_pkg::item_t w;
    int                 pb;
    pb = int'(tracker.pend_bytes);
    w = good_reply(reply_id());
    case ($urandom_range(0, 7))
      0: w.frame_extended = 1'b1;
      1: w.frame_remote = 1'b1;
      2: w.frame_id = 11'($urandom);
      3: w.frame_length = 4'($urandom_range(0, 2 + pb));
      4: w.frame_data[63:60] = 4'($urandom_range(1, 15));
      5: w.frame_data[59:56] = 4'($urandom_range(0, 1 + pb));
      6: w.frame_data[55:48] = w.frame_data[55:48] ^ 8'($urandom_range(1, 255));
      default: w.frame_data[47:40] = w.frame_data[47:40] ^ 8'($urandom_range(1, 255));
    endcase
    return w;
  endfunction

  task automatic send(input obd_m01_pkg::item_t w);
    in_if.valid          <= 1'b1;
    in_if.func           <= w.func;
    in_if.pid            <= w.pid;
    in_if.required_bytes <= w.required_bytes;
    in_if.frame_id       <= w.frame_id;
    in_if.frame_extended <= w.frame_extended;
    in_if.frame_remote   <= w.frame_remote;
    in_if.frame_length   <= w.frame_length;
    in_if.frame_data     <= w.frame_data;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tracker.word_accepted(w);
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = new_burst();
    end
  endtask

  task automatic idle_input();
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tracker.set_register(idx, val);
  endtask

  task automatic program_phase(input int ph);
    logic [10:0] lo, hi;
    // bit 10 of the timeout write is don't-care; toggle it
    write_reg(obd_m01_pkg::CFG_REQ_ID, 11'($urandom));
    case (ph)
      0: begin
        write_reg(obd_m01_pkg::CFG_TIMEOUT, 11'd1);
        write_reg(obd_m01_pkg::CFG_REQ_ID, 11'd0);
        lo = 11'd0;
        hi = 11'h7FF;
      end
      1: begin
        write_reg(obd_m01_pkg::CFG_TIMEOUT, 11'h7FF);
        write_reg(obd_m01_pkg::CFG_REQ_ID, 11'h7FF);
        lo = tracker.latched_id;
        hi = tracker.latched_id;
      end
      2: begin
        write_reg(obd_m01_pkg::CFG_TIMEOUT, 11'h400);
        lo = 11'h7FF;
        hi = 11'd0;
      end
      3: begin
        write_reg(obd_m01_pkg::CFG_TIMEOUT, {1'($urandom), 10'($urandom_range(2, 15))});
        lo = 11'($urandom_range(0, tracker.latched_id));
        hi = 11'($urandom_range(tracker.latched_id, 2047));
      end
      4: begin
        write_reg(obd_m01_pkg::CFG_TIMEOUT, 11'($urandom_range(1, 40)));
        lo = 11'd0;
        hi = tracker.latched_id - 11'd1;
      end
      default: begin
        write_reg(obd_m01_pkg::CFG_TIMEOUT, {1'($urandom), 10'($urandom_range(1, 100))});
        lo = tracker.latched_id - 11'($urandom_range(0, 8));
        hi = tracker.latched_id + 11'($urandom_range(0, 8));
      end
    endcase
    write_reg(obd_m01_pkg::CFG_RSP_LOW, lo);
    write_reg(obd_m01_pkg::CFG_RSP_HIGH, hi);
  endtask

  // One request with noise in its wait, followed by a reply or by up to 40 ticks while it stays open.
  task automatic run_exchange();
    int n;
    send(start_word(8'($urandom), 3'($urandom_range(0, 7))));
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0, 1: send(kind_word(obd_m01_pkg::FUNC_TICK));
        2, 3: send(broken_reply());
        default: send(kind_word(2'($urandom_range(0, 3))));
      endcase
    end
    if ($urandom_range(0, 99) < 75) begin
      send(good_reply(reply_id()));
    end else begin
      for (n = 0; n < 40 && tracker.waiting; n++) send(kind_word(obd_m01_pkg::FUNC_TICK));
    end
  endtask

  initial begin : result_sink
    int                   seg_left, mode, hold_left, phase_n;
    bit                   rdy;
    obd_m01_pkg::result_t got;
    out_if.ready = 1'b0;
    seg_left  = 0;
    hold_left = 0;
    phase_n   = 0;
    mode      = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.event_res  = obd_m01_pkg::event_e'(out_if.event_res);
        got.tx_id      = out_if.tx_id;
        got.tx_payload = out_if.tx_payload;
        got.ecu_id     = out_if.ecu_id;
        got.reply_data = out_if.reply_data;
        tracker.result_seen(got);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      phase_n++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = (phase_n % 5) < 3;
        endcase
      end
      out_if.ready <= rdy;
    end
  end

  initial begin
    obd_m01_pkg::item_t w;
    int unsigned        target;
    cycle_cnt            = 0;
    long_hold_req        = 1'b0;
    burst_left           = new_burst();
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.func           = '0;
    in_if.pid            = '0;
    in_if.required_bytes = '0;
    in_if.frame_id       = '0;
    in_if.frame_extended = 1'b0;
    in_if.frame_remote   = 1'b0;
    in_if.frame_length   = '0;
    in_if.frame_data     = '0;
    tracker.power_on();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words against the reset register values
    send(kind_word(obd_m01_pkg::FUNC_TICK));
    send(good_reply(11'h7E8));
    send(kind_word(FUNC_BAD));
    send(start_word(8'h0C, 3'd2));
    w = good_reply(11'h7E8); w.frame_extended = 1'b1; send(w);
    w = good_reply(11'h7E8); w.frame_remote = 1'b1; send(w);
    send(good_reply(11'h7E7));
    send(good_reply(11'h7F0));
    w = good_reply(11'h7E8); w.frame_length = 4'd4; send(w);
    w = good_reply(11'h7E8); w.frame_data[63:56] = 8'h14; send(w);
    w = good_reply(11'h7E8); w.frame_data[59:56] = 4'd3; send(w);
    w = good_reply(11'h7E8); w.frame_data[55:48] = 8'h40; send(w);
    w = good_reply(11'h7E8); w.frame_data[47:40] = 8'h0D; send(w);
    // length code above 8, first ECU to answer gets latched
    w = good_reply(11'h7EF); w.frame_length = 4'd15; w.frame_data[59:56] = 4'hF; send(w);
    send(good_reply(11'h7EF));
    send(start_word(8'hFF, 3'd7));
    send(good_reply(11'h7E8));
    w = good_reply(11'h7EF); w.frame_length = 4'd7; w.frame_data[59:56] = 4'd6; send(w);
    send(start_word(8'h00, 3'd0));
    send(kind_word(obd_m01_pkg::FUNC_TICK));
    w = good_reply(11'h7EF); w.frame_length = 4'd3; w.frame_data[59:56] = 4'd2; send(w);
    send(start_word(8'h05, 3'd1));
    send(start_word(8'h06, 3'd1));
    w = good_reply(11'h7EF); w.frame_data[47:40] = 8'h05; send(w);
    send(good_reply(11'h7EF));

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_input();
      wait_drained();
      program_phase(ph);
      if (ph == 3) long_hold_req = 1'b1;
      target = tracker.active_words + PHASE_WORDS;
      while (tracker.active_words < target) begin
        if ($urandom_range(0, 99) < 80) run_exchange();
        else send(kind_word(2'($urandom_range(0, 3))));
      end
    end

    idle_input();
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d words, %0d inside open requests, over %0d register settings.",
             tracker.all_words, tracker.active_words, PHASES + 1);
    $display("Results: %0d requests, %0d replies, %0d timeouts, %0d ignored, %0d idle.",
             tracker.ev_seen[obd_m01_pkg::EV_REQUEST], tracker.ev_seen[obd_m01_pkg::EV_ACCEPTED],
             tracker.ev_seen[obd_m01_pkg::EV_TIMEOUT], tracker.ev_seen[obd_m01_pkg::EV_IGNORED],
             tracker.ev_seen[obd_m01_pkg::EV_NOTHING]);
    if (tracker.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### obd_mode01_response_filter.f
hdl/obd_m01_pkg.sv
hdl/obd_m01_if.sv
hdl/obd_m01_chk.sv
hdl/obd_m01_core.sv
hdl/obd_mode01_response_filter.sv
tb/obd_mode01_response_filter_tb.sv
